/* sv/graph_bfs_dfs_traversal_core_macros.svh */
// Assertion macros shared by the graph traversal core checker.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef GRAPH_BFS_DFS_TRAVERSAL_CORE_MACROS_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GBT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gbt_pkg.sv */
// Shared types and constants for the graph traversal core.
// No dependencies; imported by the core and its checker.
package gbt_pkg;

  localparam int VERTEX_W = 5;
  localparam int COUNT_W  = 6;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [COUNT_W-1:0] VC_RESET = 6'd32;

  // Register index, taken from paddr bit 2
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_BFS      = 2'd1,
    OP_DFS      = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

endpackage

/* sv/graph_bfs_dfs_traversal_core.sv */
// Graph traversal core: add-edge reads and updates the row of each endpoint in turn,
// clear empties the matrix; BFS and DFS loop through the adjacency row read and
// the lowest-bit encoder for each visited vertex. One request at a time.
// Reset (async, active low) empties the matrix at once and sets vertex_count to 32.
module graph_bfs_dfs_traversal_core #(
  parameter int MAX_NODES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [gbt_pkg::VERTEX_W-1:0]  vertex_a_i,
  input  logic [gbt_pkg::VERTEX_W-1:0]  vertex_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gbt_pkg::VERTEX_W-1:0]  vertex_o,
  output logic                          last_o,
  output logic                          error_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbt_pkg::ADDR_W-1:0]    paddr,
  input  logic [gbt_pkg::DATA_W-1:0]    pwdata,
  output logic [gbt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  import gbt_pkg::*;

  localparam int N  = MAX_NODES;
  localparam int VW = $clog2(N);
  localparam int PW = $clog2(N + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_ERR,
    ST_B_ROW,
    ST_B_PUSH,
    ST_B_EMIT,
    ST_D_PICK,
    ST_D_POP,
    ST_D_FIN
  } state_e;

  state_e                state_q, state_d;
  logic [COUNT_W-1:0]    vc_q, vc_d;
  logic [N-1:0]          visited_q, visited_d;
  logic [PW-1:0]         head_q, head_d;
  logic [PW-1:0]         tail_q, tail_d;
  logic [VW-1:0]         u_q, u_d;
  logic [N-1:0]          cand_q, cand_d;
  logic                  first_q, first_d;
  logic [VW-1:0]         ea_q, ea_d;
  logic [VW-1:0]         eb_q, eb_d;
  logic                  out_valid_q, out_valid_d;
  logic [VERTEX_W-1:0]   out_vertex_q, out_vertex_d;
  logic                  out_last_q, out_last_d;
  logic                  out_error_q, out_error_d;

  logic [PW-1:0]         n_eff;
  logic [N-1:0]          lim;
  logic [N-1:0]          row_m;
  logic [N-1:0]          enc_in;
  logic                  nb_found;
  logic [VW-1:0]         nb;
  logic [N-1:0]          nb_bit;
  logic                  slot_free;
  logic                  a_ok;
  logic                  b_ok;
  logic [VW-1:0]         a_idx;
  logic [PW-1:0]         tail_m2;
  logic                  tail_room;
  logic                  cfg_we;

  logic                  adj_clr;
  logic                  adj_rd_en;
  logic [VW-1:0]         adj_rd_addr;
  logic [N-1:0]          adj_rd_data;
  logic                  adj_wr_en;
  logic [VW-1:0]         adj_wr_addr;
  logic [N-1:0]          adj_wr_data;

  logic                  pend_wr_en;
  logic [VW-1:0]         pend_wr_addr;
  logic [VW-1:0]         pend_wr_data;
  logic                  pend_rd_en;
  logic [VW-1:0]         pend_rd_addr;
  logic [VW-1:0]         pend_rd_data;

  gbt_adj_ram #(.N(N)) u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (adj_clr),
    .rd_en_i   (adj_rd_en),
    .rd_addr_i (adj_rd_addr),
    .rd_data_o (adj_rd_data),
    .wr_en_i   (adj_wr_en),
    .wr_addr_i (adj_wr_addr),
    .wr_data_i (adj_wr_data)
  );

  gbt_pend_ram #(.N(N), .DW(VW)) u_pend (
    .clk_i     (clk_i),
    .wr_en_i   (pend_wr_en),
    .wr_addr_i (pend_wr_addr),
    .wr_data_i (pend_wr_data),
    .rd_en_i   (pend_rd_en),
    .rd_addr_i (pend_rd_addr),
    .rd_data_o (pend_rd_data)
  );

  gbt_lowbit #(.W(N)) u_lowbit (
    .vec_i   (enc_in),
    .found_o (nb_found),
    .idx_o   (nb)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
  assign vc_d   = cfg_we ? pwdata[COUNT_W-1:0] : vc_q;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? DATA_W'(vc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VC_RESET;
    end else begin
      vc_q <= vc_d;
    end
  end

  // Effective vertex count, saturated to the matrix size
  assign n_eff = (32'(vc_q) > N) ? PW'(N) : PW'(vc_q);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      lim[i] = (32'(i) < 32'(n_eff));
    end
  end

  assign a_ok      = (32'(vertex_a_i) < 32'(n_eff));
  assign b_ok      = (32'(vertex_b_i) < 32'(n_eff));
  assign a_idx     = VW'(vertex_a_i);
  assign row_m     = adj_rd_data & lim & ~visited_q;
  assign enc_in    = (state_q == ST_B_PUSH && !first_q) ? cand_q : row_m;
  assign nb_bit    = N'(1) << nb;
  assign slot_free = !out_valid_q || out_ready_i;
  assign tail_m2   = tail_q - PW'(2);
  assign tail_room = (32'(tail_q) < N);

  always_comb begin
    state_d      = state_q;
    visited_d    = visited_q;
    head_d       = head_q;
    tail_d       = tail_q;
    u_d          = u_q;
    cand_d       = cand_q;
    first_d      = first_q;
    ea_d         = ea_q;
    eb_d         = eb_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_vertex_d = out_vertex_q;
    out_last_d   = out_last_q;
    out_error_d  = out_error_q;

    adj_clr      = 1'b0;
    adj_rd_en    = 1'b0;
    adj_rd_addr  = '0;
    adj_wr_en    = 1'b0;
    adj_wr_addr  = '0;
    adj_wr_data  = '0;
    pend_wr_en   = 1'b0;
    pend_wr_addr = '0;
    pend_wr_data = '0;
    pend_rd_en   = 1'b0;
    pend_rd_addr = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(operation_i))
            OP_ADD_EDGE: begin
              // Drop edges with an endpoint outside the active count
              if (a_ok && b_ok) begin
                ea_d        = a_idx;
                eb_d        = VW'(vertex_b_i);
                adj_rd_en   = 1'b1;
                adj_rd_addr = a_idx;
                state_d     = ST_ADD_A;
              end
            end
            OP_CLEAR: begin
              adj_clr = 1'b1;
            end
            OP_BFS, OP_DFS: begin
              if (!a_ok) begin
                state_d = ST_ERR;
              end else begin
                visited_d    = N'(1) << a_idx;
                pend_wr_en   = 1'b1;
                pend_wr_addr = '0;
                pend_wr_data = a_idx;
                tail_d       = PW'(1);
                head_d       = PW'(1);
                adj_rd_en    = 1'b1;
                adj_rd_addr  = a_idx;
                u_d          = a_idx;
                first_d      = 1'b1;
                state_d      = (op_e'(operation_i) == OP_BFS) ? ST_B_PUSH : ST_D_PICK;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_ADD_A: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = ea_q;
        adj_wr_data = adj_rd_data | (N'(1) << eb_q);
        adj_rd_en   = 1'b1;
        adj_rd_addr = eb_q;
        state_d     = ST_ADD_B;
      end

      ST_ADD_B: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = eb_q;
        adj_wr_data = adj_rd_data | (N'(1) << ea_q);
        state_d     = ST_IDLE;
      end

      ST_ERR: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = '0;
          out_last_d   = 1'b1;
          out_error_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      ST_B_ROW: begin
        u_d         = pend_rd_data;
        adj_rd_en   = 1'b1;
        adj_rd_addr = pend_rd_data;
        first_d     = 1'b1;
        state_d     = ST_B_PUSH;
      end

      ST_B_PUSH: begin
        // Enqueue unvisited neighbors, lowest first, one per cycle
        first_d = 1'b0;
        if (nb_found && tail_room) begin
          pend_wr_en   = 1'b1;
          pend_wr_addr = tail_q[VW-1:0];
          pend_wr_data = nb;
          tail_d       = tail_q + PW'(1);
          visited_d    = visited_q | nb_bit;
          cand_d       = enc_in & ~nb_bit;
        end else begin
          state_d = ST_B_EMIT;
        end
      end

      ST_B_EMIT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = VERTEX_W'(u_q);
          out_last_d   = (head_q == tail_q);
          out_error_d  = 1'b0;
          if (head_q == tail_q) begin
            state_d = ST_IDLE;
          end else begin
            pend_rd_en   = 1'b1;
            pend_rd_addr = head_q[VW-1:0];
            head_d       = head_q + PW'(1);
            state_d      = ST_B_ROW;
          end
        end
      end

      ST_D_PICK: begin
        if (nb_found && tail_room) begin
          // Release the held result only once a successor exists
          if (slot_free) begin
            out_valid_d  = 1'b1;
            out_vertex_d = VERTEX_W'(u_q);
            out_last_d   = 1'b0;
            out_error_d  = 1'b0;
            u_d          = nb;
            pend_wr_en   = 1'b1;
            pend_wr_addr = tail_q[VW-1:0];
            pend_wr_data = nb;
            tail_d       = tail_q + PW'(1);
            visited_d    = visited_q | nb_bit;
            adj_rd_en    = 1'b1;
            adj_rd_addr  = nb;
          end
        end else if (tail_q == PW'(1)) begin
          tail_d  = '0;
          state_d = ST_D_FIN;
        end else begin
          tail_d       = tail_q - PW'(1);
          pend_rd_en   = 1'b1;
          pend_rd_addr = tail_m2[VW-1:0];
          state_d      = ST_D_POP;
        end
      end

      ST_D_POP: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = pend_rd_data;
        state_d     = ST_D_PICK;
      end

      ST_D_FIN: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = VERTEX_W'(u_q);
          out_last_d   = 1'b1;
          out_error_d  = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      visited_q    <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      first_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_vertex_q <= '0;
      out_last_q   <= 1'b0;
      out_error_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      visited_q    <= visited_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      first_q      <= first_d;
      out_valid_q  <= out_valid_d;
      out_vertex_q <= out_vertex_d;
      out_last_q   <= out_last_d;
      out_error_q  <= out_error_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    cand_q <= cand_d;
    ea_q   <= ea_d;
    eb_q   <= eb_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign vertex_o    = out_vertex_q;
  assign last_o      = out_last_q;
  assign error_o     = out_error_q;

endmodule

/* sv/gbt_lowbit.sv */
// Lowest-set-bit encoder, the shared search unit of the traversal sequencer.
// Standalone; no package dependency.
module gbt_lowbit #(
  parameter int W = 32
) (
  input  logic [W-1:0]         vec_i,
  output logic                 found_o,
  output logic [$clog2(W)-1:0] idx_o
);

  localparam int IW = $clog2(W);

  logic [W-1:0] iso;

  // Isolate the lowest set bit, then encode the one-hot word
  assign iso     = vec_i & (~vec_i + W'(1));
  assign found_o = |vec_i;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < W; i++) begin
      if (iso[i]) begin
        idx_o = idx_o | IW'(i);
      end
    end
  end

endmodule

/* sv/gbt_adj_ram.sv */
// Adjacency matrix store: one row of neighbor bits per vertex, registered read.
// Row valid flags give the all-zero reset and the clear of the whole matrix.
module gbt_adj_ram #(
  parameter int N = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  logic                 rd_en_i,
  input  logic [$clog2(N)-1:0] rd_addr_i,
  output logic [N-1:0]         rd_data_o,
  input  logic                 wr_en_i,
  input  logic [$clog2(N)-1:0] wr_addr_i,
  input  logic [N-1:0]         wr_data_i
);

  logic [N-1:0] mem [N];
  logic [N-1:0] row_vld_q;
  logic [N-1:0] rd_q;
  logic         rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
      if (clr_i) begin
        row_vld_q <= '0;
      end else if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // A row never written since the last clear reads as empty
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* sv/gbt_pend_ram.sv */
// Pending-vertex store: BFS queue or DFS stack, one write and one read port.
// Registered read; contents undefined until written.
module gbt_pend_ram #(
  parameter int N  = 32,
  parameter int DW = 5
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [$clog2(N)-1:0] wr_addr_i,
  input  logic [DW-1:0]        wr_data_i,
  input  logic                 rd_en_i,
  input  logic [$clog2(N)-1:0] rd_addr_i,
  output logic [DW-1:0]        rd_data_o
);

  logic [DW-1:0] mem [N];
  logic [DW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* sv/gbt_checker.sv */
// Port-level checker for the graph traversal core, bound to the top level.
// Depends on gbt_pkg and graph_bfs_dfs_traversal_core_macros.svh.
`include "graph_bfs_dfs_traversal_core_macros.svh"

module gbt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [1:0]                   operation_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [gbt_pkg::VERTEX_W-1:0] vertex_o,
  input logic                         last_o,
  input logic                         error_o
);

  import gbt_pkg::*;

  // Hold a stalled result
  `GBT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(vertex_o) && $stable(last_o) && $stable(error_o), "stalled result changed")

  // An error result is always the only, final one, with vertex zero
  `GBT_ASSERT_SAME(a_err_form, out_valid_o && error_o, last_o && (vertex_o == '0), "malformed error result")

  // Busy until the final result of a traversal is out
  `GBT_ASSERT_SAME(a_busy_mid, out_valid_o && !last_o, !in_ready_o, "request taken mid-traversal")

  // Edge and clear requests produce no result
  `GBT_ASSERT_NEXT(a_no_result, in_valid_i && in_ready_o && ((operation_i == OP_ADD_EDGE) || (operation_i == OP_CLEAR)), !$rose(out_valid_o), "result after edge or clear request")

endmodule

bind graph_bfs_dfs_traversal_core gbt_checker u_gbt_checker (.*);
